>>> src/binary_morphology_erode_dilate_assert.svh
`ifndef BINARY_MORPHOLOGY_ERODE_DILATE_ASSERT_SVH
`define BINARY_MORPHOLOGY_ERODE_DILATE_ASSERT_SVH

// same-cycle check, sampled on clk, off while rst_n is low
`define BMED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check
`define BMED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bmed_pkg.sv
`timescale 1ns / 1ps
package bmed_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_W      = 11;
  localparam int MASK_W     = 9;
  localparam int PIX_W      = 8;

  localparam logic [PIX_W-1:0] FG_PIX = 8'hFF;
  localparam logic [PIX_W-1:0] BG_PIX = 8'h00;

  localparam logic [DIM_W-1:0]  HEIGHT_LIMIT = 11'd1024;
  localparam logic [DIM_W-1:0]  WIDTH_RST    = 11'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST   = 11'd480;
  localparam logic [MASK_W-1:0] MASK_RST     = 9'h1FF;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd3;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] in_pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             out_last;
  } out_t;

  // per-request control from the counters to the window stage
  typedef struct packed {
    logic wr;     // pixel goes into line store and window
    logic emit;   // request produces a result
    logic inner;  // result position is away from the frame border
    logic last;   // final result of the frame
  } ctl_t;

endpackage

>>> src/bmed_line_buf.sv
`timescale 1ns / 1ps
module bmed_line_buf #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;
  logic [WIDTH-1:0] byp_r;
  logic             byp_hit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  // same-edge write and read of one column: forward the new word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (re) begin
      byp_hit_r <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      byp_r <= wdata;
    end
  end

  assign rdata = byp_hit_r ? byp_r : rd_r;

endmodule

>>> src/bmed_window.sv
`timescale 1ns / 1ps
module bmed_window #(
  parameter int MASK_SIZE = 3
) (
  input  logic                                           clk,
  input  logic                                           shift,
  input  logic                                           fg,
  input  logic [((MASK_SIZE > 1) ? MASK_SIZE - 1 : 1)-1:0] rd_word,
  input  logic                                           op_mode,
  input  logic [bmed_pkg::MASK_W-1:0]                    mask_bits,
  input  logic                                           inner,
  output logic [((MASK_SIZE > 1) ? MASK_SIZE - 1 : 1)-1:0] wr_word,
  output logic                                           res_fg
);

  import bmed_pkg::*;

  localparam int LB_W  = (MASK_SIZE > 1) ? MASK_SIZE - 1 : 1;
  localparam int WIN_N = (MASK_SIZE > 1) ? MASK_SIZE - 1 : 1;
  localparam int NCELL = MASK_SIZE * MASK_SIZE;
  localparam int MW    = (NCELL > MASK_W) ? NCELL : MASK_W;

  logic [MASK_SIZE-1:0] win_r [WIN_N];
  logic [MASK_SIZE-1:0] wnd   [MASK_SIZE];
  logic [LB_W:0]        ext;
  logic [MASK_SIZE-1:0] col_new;
  logic [NCELL-1:0]     wbits;
  logic [NCELL-1:0]     tmask;
  logic [MW-1:0]        mask_ext;
  logic                 all_fg;
  logic                 any_fg;

  // bit 0 is the current row, bit j the row j lines above
  assign ext     = {rd_word, fg};
  assign col_new = ext[MASK_SIZE-1:0];
  assign wr_word = ext[LB_W-1:0];

  always_comb begin
    for (int v = 0; v < MASK_SIZE - 1; v++) begin
      wnd[v] = win_r[v];
    end
    wnd[MASK_SIZE-1] = col_new;
    for (int u = 0; u < MASK_SIZE; u++) begin
      for (int v = 0; v < MASK_SIZE; v++) begin
        wbits[u*MASK_SIZE+v] = wnd[v][MASK_SIZE-1-u];
      end
    end
  end

  assign mask_ext = MW'(mask_bits);
  assign tmask    = mask_ext[NCELL-1:0];
  assign all_fg   = &(~tmask | wbits);
  assign any_fg   = |(tmask & wbits);
  assign res_fg   = inner && ((op_mode == MODE_DILATE) ? any_fg : all_fg);

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int k = 0; k < WIN_N - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[WIN_N-1] <= col_new;
    end
  end

endmodule

>>> src/bmed_ctrl.sv
`timescale 1ns / 1ps
module bmed_ctrl #(
  parameter int MASK_SIZE = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bmed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmed_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_fire,
  input  bmed_pkg::in_t                   in_data,
  output bmed_pkg::ctl_t                  ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]    col,
  output logic                            op_mode,
  output logic [bmed_pkg::MASK_W-1:0]     mask_bits
);

  import bmed_pkg::*;

  `include "binary_morphology_erode_dilate_assert.svh"

  localparam int HALF   = MASK_SIZE / 2;
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int XW     = ((WW > DIM_W) ? WW : DIM_W) + 1;
  localparam int LAGMAX = HALF * MAX_WIDTH + HALF;
  localparam int LW     = (LAGMAX > 0) ? $clog2(LAGMAX + 1) : 1;

  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic              mode_r, mode_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [AW-1:0]     col_r, col_nxt;
  logic [DIM_W-1:0]  orow_r, orow_nxt;
  logic [AW-1:0]     ocol_r, ocol_nxt;
  logic [LW-1:0]     lead_r, lead_nxt;

  logic [WW-1:0]     w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [LW-1:0]     lag;
  logic              in_done;
  logic              out_done;
  logic              col_ok;
  logic              col_end;
  logic              ocol_end;
  logic              orow_end;
  logic              pix_go;
  logic              restart;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (XW'(width_r) > XW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_r > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = height_r;
    end
  end

  assign lag      = LW'(LW'(w_eff) * LW'(HALF)) + LW'(HALF);
  assign in_done  = row_r >= h_eff;
  assign out_done = orow_r >= h_eff;
  assign col_ok   = XW'(col_r) < XW'(w_eff);
  assign col_end  = (XW'(col_r) + XW'(1)) >= XW'(w_eff);
  assign ocol_end = (XW'(ocol_r) + XW'(1)) == XW'(w_eff);
  assign orow_end = (XW'(orow_r) + XW'(1)) == XW'(h_eff);
  assign pix_go   = (in_data.func == FUNC_PIXEL) && !in_done && col_ok;

  always_comb begin
    ctl.wr    = pix_go;
    ctl.emit  = pix_go ? (lead_r == lag)
                       : ((in_data.func == FUNC_FLUSH) && in_done && !out_done);
    ctl.last  = ocol_end && orow_end;
    ctl.inner = (XW'(orow_r) >= XW'(HALF)) &&
                ((XW'(orow_r) + XW'(HALF)) < XW'(h_eff)) &&
                (XW'(ocol_r) >= XW'(HALF)) &&
                ((XW'(ocol_r) + XW'(HALF)) < XW'(w_eff));
  end

  assign col       = col_r;
  assign op_mode   = mode_r;
  assign mask_bits = mask_r;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    mode_nxt   = mode_r;
    mask_nxt   = mask_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    lead_nxt   = lead_r;
    restart    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          width_nxt = cfg_data;
          restart   = 1'b1;
        end
        CFG_HEIGHT: begin
          height_nxt = cfg_data;
          restart    = 1'b1;
        end
        CFG_MODE: mode_nxt = cfg_data[0];
        CFG_MASK: mask_nxt = cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end else if (in_fire) begin
      if (pix_go) begin
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_r + DIM_W'(1);
        end else begin
          col_nxt = col_r + AW'(1);
        end
        if (!ctl.emit) begin
          lead_nxt = lead_r + LW'(1);
        end
      end
      if (ctl.emit) begin
        if (ctl.last) begin
          restart = 1'b1;
        end else if (ocol_end) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + DIM_W'(1);
        end else begin
          ocol_nxt = ocol_r + AW'(1);
        end
      end
      if ((in_data.func == FUNC_FLUSH) && in_done && out_done) begin
        restart = 1'b1;
      end
    end
    if (restart) begin
      row_nxt  = '0;
      col_nxt  = '0;
      orow_nxt = '0;
      ocol_nxt = '0;
      lead_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      mode_r   <= MODE_ERODE;
      mask_r   <= MASK_RST;
      row_r    <= '0;
      col_r    <= '0;
      orow_r   <= '0;
      ocol_r   <= '0;
      lead_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      mode_r   <= mode_nxt;
      mask_r   <= mask_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      orow_r   <= orow_nxt;
      ocol_r   <= ocol_nxt;
      lead_r   <= lead_nxt;
    end
  end

  `BMED_ASSERT_NOW(a_row_bound, 1'b1, row_r <= h_eff, "input row past frame height")
  `BMED_ASSERT_NOW(a_lead_bound, 1'b1, lead_r <= lag, "input lead past window lag")
  `BMED_ASSERT_NEXT(a_last_restart, in_fire && ctl.emit && ctl.last && !cfg_we,
    (row_r == '0) && (orow_r == '0) && (lead_r == '0), "frame end did not restart")

endmodule

>>> src/binary_morphology_erode_dilate.sv
`timescale 1ns / 1ps
// Binary erosion / dilation over a MASK_SIZE square window on a raster pixel stream.
// Input channel (in_valid/in_ready/in_data): one request per pixel, func selects
// a pixel or a flush request. A pixel counts as foreground only when it is 255.
// Result channel (out_valid/out_ready/out_data): 255 or 0, out_last on the final
// pixel of the frame. Results trail the input by half a window (rows and columns);
// once the frame is in, flush requests drain the remaining bottom rows.
// Configuration (cfg_we/cfg_index/cfg_data): width, height, mode and mask,
// written only while the stream is idle (a user rule, not enforced by the block);
// a size write restarts the frame. Throughput: one request per clock while in_ready
// is high. A pixel is registered in the input stage, its column is read from the
// line store in the same edge, and the window result is registered as it leaves.
// Reset clears counters and loads the default configuration; the line store is
// not cleared, every column is rewritten before it is used.
// When out_ready is low the result register holds; requests keep entering the input
// stage until one that produces a result waits there, then in_ready drops until the
// result is taken.
module binary_morphology_erode_dilate #(
  parameter int MASK_SIZE = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bmed_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bmed_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [bmed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmed_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bmed_pkg::*;

  `include "binary_morphology_erode_dilate_assert.svh"

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int LB_W = (MASK_SIZE > 1) ? MASK_SIZE - 1 : 1;

  ctl_t              ctl;
  logic [AW-1:0]     col;
  logic              op_mode;
  logic [MASK_W-1:0] mask_bits;

  logic              s1_valid_r;
  ctl_t              s1_ctl_r;
  logic              s1_fg_r;
  logic [AW-1:0]     s1_col_r;
  logic              out_valid_r;
  out_t              out_r;

  logic              in_fire;
  logic              out_free;
  logic              s1_adv;
  logic              lb_we;
  logic [LB_W-1:0]   rd_word;
  logic [LB_W-1:0]   wr_word;
  logic              res_fg;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_ctl_r.emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign lb_we    = s1_adv && s1_ctl_r.wr;

  bmed_ctrl #(
    .MASK_SIZE (MASK_SIZE),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .ctl       (ctl),
    .col       (col),
    .op_mode   (op_mode),
    .mask_bits (mask_bits)
  );

  bmed_line_buf #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (LB_W)
  ) u_line_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (in_fire),
    .raddr (col),
    .we    (lb_we),
    .waddr (s1_col_r),
    .wdata (wr_word),
    .rdata (rd_word)
  );

  bmed_window #(
    .MASK_SIZE (MASK_SIZE)
  ) u_window (
    .clk       (clk),
    .shift     (lb_we),
    .fg        (s1_fg_r),
    .rd_word   (rd_word),
    .op_mode   (op_mode),
    .mask_bits (mask_bits),
    .inner     (s1_ctl_r.inner),
    .wr_word   (wr_word),
    .res_fg    (res_fg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        s1_ctl_r   <= ctl;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_ctl_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_fg_r  <= (in_data.in_pixel == FG_PIX);
      s1_col_r <= col;
    end
    if (s1_adv && s1_ctl_r.emit) begin
      out_r.out_pixel <= res_fg ? FG_PIX : BG_PIX;
      out_r.out_last  <= s1_ctl_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `BMED_ASSERT_NOW(a_out_binary, out_valid_r,
    (out_r.out_pixel == FG_PIX) || (out_r.out_pixel == BG_PIX), "result not binary")
  `BMED_ASSERT_NEXT(a_stall_hold, s1_valid_r && s1_ctl_r.emit && !out_free,
    s1_valid_r && s1_ctl_r.emit, "pending result dropped under stall")

endmodule
